// ===== sv/csm_pkg.sv =====
package csm_pkg;

  localparam int unsigned CACHE_DEPTH = 65536;
  localparam int unsigned ADDR_W      = $clog2(CACHE_DEPTH);
  localparam int unsigned VAL_W       = 64;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned CFG_W       = 17;
  localparam int unsigned LIM_W       = (CFG_W > ADDR_W + 1) ? CFG_W : ADDR_W + 1;
  localparam int unsigned IN_DATA_W   = 80;

  localparam logic [CFG_W-1:0] CFG_RESET    = CFG_W'(65536);
  localparam logic [VAL_W-1:0] TRIPLE_LIMIT = 64'h5555_5555_5555_5554;

  localparam logic KIND_COMPUTE = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  typedef struct packed {
    logic capture;
    logic preload;
    logic first_rd;
    logic eval;
    logic clr;
    logic out_load;
  } csm_cmd_t;

  typedef struct packed {
    logic kind;
    logic fin;
    logic clr_last;
    logic out_free;
  } csm_status_t;

endpackage

// ===== sv/csm_ctrl.sv =====
module csm_ctrl import csm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  csm_status_t status_i,
  output csm_cmd_t    cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        if (status_i.kind == KIND_PRELOAD) begin
          cmd_o.preload = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.first_rd = 1'b1;
          state_d        = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.fin) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/csm_datapath.sv =====
module csm_datapath import csm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csm_cmd_t             cmd_i,
  output csm_status_t          status_o,
  input  logic                 in_kind_i,
  input  logic [VAL_W-1:0]     in_start_i,
  input  logic [CNT_W-1:0]     in_steps_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CNT_W-1:0]     out_count_o,
  output logic                 out_ovf_o
);

  logic [CNT_W-1:0] memo_q [CACHE_DEPTH];
  logic [CNT_W-1:0] rd_q;

  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(CACHE_DEPTH);

  logic [CFG_W-1:0]  limit_q;
  logic [LIM_W-1:0]  lim_eff;
  logic              kind_q;
  logic [VAL_W-1:0]  start_q, y_q, y_step;
  logic [CNT_W-1:0]  steps_q, cnt_q;
  logic              ovf_q;
  logic [ADDR_W-1:0] clr_q;
  logic              out_valid_q, out_ovf_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic              y_le1, y_in, start_in, hit, at_max, trip_ovf, fin;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  sum_sat;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [CNT_W-1:0]  mem_wd;

  always_comb begin
    lim_eff  = (LIM_W'(limit_q) > DEPTH_L) ? DEPTH_L : LIM_W'(limit_q);
    y_le1    = (y_q[VAL_W-1:1] == '0);
    y_in     = (y_q[VAL_W-1:LIM_W] == '0) && (y_q[LIM_W-1:0] < lim_eff);
    start_in = (start_q[VAL_W-1:LIM_W] == '0) && (start_q[LIM_W-1:0] < lim_eff);
    hit      = !y_le1 && y_in && (rd_q != '0);
    at_max   = &cnt_q;
    trip_ovf = y_q[0] && (y_q > TRIPLE_LIMIT);
    fin      = y_le1 || hit || at_max || trip_ovf;
    sum      = {1'b0, cnt_q} + {1'b0, rd_q};
    sum_sat  = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    y_step   = y_q[0] ? (y_q + {y_q[VAL_W-2:0], 1'b0} + VAL_W'(1)) : (y_q >> 1);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = start_q[ADDR_W-1:0];
    mem_wd = sum_sat;
    if (cmd_i.clr) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (cmd_i.preload) begin
      mem_we = (start_q[VAL_W-1:ADDR_W] == '0);
      mem_wd = steps_q;
    end else if (cmd_i.eval) begin
      mem_we = hit && start_in;
    end
    mem_ra = cmd_i.first_rd ? start_q[ADDR_W-1:0] : y_step[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      memo_q[mem_wa] <= mem_wd;
    end
    rd_q <= memo_q[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= in_kind_i;
      start_q <= in_start_i;
      steps_q <= in_steps_i;
      y_q     <= in_start_i;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.eval && !y_le1) begin
      if (hit) begin
        cnt_q <= sum_sat;
      end else if (!at_max) begin
        if (trip_ovf) begin
          ovf_q <= 1'b1;
        end else begin
          y_q   <= y_step;
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
    if (cmd_i.out_load) begin
      out_cnt_q <= cnt_q;
      out_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= CFG_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.kind     = kind_q;
  assign status_o.fin      = fin;
  assign status_o.clr_last = &clr_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_cnt_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

// ===== sv/collatz_step_counter_memo.sv =====
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: start_value, entry_steps
// m_axis   out  m_axis_tvalid/m_axis_tready   tuser: overflow; tdata: step_count
// cfg      in   cfg_valid_i/cfg_ready_o       cfg_data_i: cache_limit
//
// A compute request reads the memo, steps and loads its result; a preload writes the memo.
// Each step is one memo read in the same cycle as one 64-bit 3y+1 add.
// After reset a clearing pass writes zero to all 65536 memo entries, one per cycle;
// no request is taken during it, configuration writes are.
// The result register lets the next request enter while a result waits on m_axis_tready.
module collatz_step_counter_memo import csm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // [63:0] start_value, [79:64] entry_steps
  input  logic                 s_axis_tuser,  // [0] kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [CNT_W-1:0]     m_axis_tdata,  // [15:0] step_count
  output logic                 m_axis_tuser,  // [0] overflow
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  csm_cmd_t    cmd;
  csm_status_t status;

  assign cfg_ready_o = 1'b1;

  csm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  csm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_kind_i   (s_axis_tuser),
    .in_start_i  (s_axis_tdata[VAL_W-1:0]),
    .in_steps_i  (s_axis_tdata[IN_DATA_W-1:VAL_W]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_count_o (m_axis_tdata),
    .out_ovf_o   (m_axis_tuser)
  );

endmodule

// ===== sim/collatz_steps_checker.sv =====
`timescale 1ns / 100ps

module collatz_steps_checker import csm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  logic [IN_DATA_W-1:0] req_data_i,   // [63:0] start_value, [79:64] entry_steps
  input  logic                 req_kind_i,   // [0] kind
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [CNT_W-1:0]     res_count_i,  // [15:0] step_count
  input  logic                 res_overflow_i,  // [0] overflow
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int unsigned COUNT_MAX = (1 << CNT_W) - 1;

  typedef struct packed {
    logic [CNT_W-1:0] steps;
    logic             overflow;
  } steps_result_t;

  logic [CNT_W-1:0] memo_steps [CACHE_DEPTH];
  logic [CFG_W-1:0] cache_limit;
  steps_result_t    expected_results [$];

  task automatic count_collatz_steps(input logic [VAL_W-1:0] start,
                                     output steps_result_t res);
    logic [VAL_W-1:0] y;
    longint unsigned  lim;
    int unsigned      cnt;
    logic             ovf;
    logic             done;
    y    = start;
    lim  = (cache_limit > CACHE_DEPTH) ? CACHE_DEPTH : cache_limit;
    cnt  = 0;
    ovf  = 1'b0;
    done = 1'b0;
    while (y > 1 && !done) begin
      if (y < lim && memo_steps[y[ADDR_W-1:0]] != '0) begin
        cnt = cnt + memo_steps[y[ADDR_W-1:0]];
        if (cnt > COUNT_MAX) cnt = COUNT_MAX;
        if (start < lim) memo_steps[start[ADDR_W-1:0]] = CNT_W'(cnt);
        done = 1'b1;
      end else if (cnt >= COUNT_MAX) begin
        done = 1'b1;
      end else if (!y[0]) begin
        y   = y >> 1;
        cnt = cnt + 1;
      end else if (y > TRIPLE_LIMIT) begin
        ovf  = 1'b1;
        done = 1'b1;
      end else begin
        y   = y * 3 + 1;
        cnt = cnt + 1;
      end
    end
    res.steps    = CNT_W'(cnt);
    res.overflow = ovf;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    steps_result_t want;
    if (!rst_ni) begin
      foreach (memo_steps[i]) memo_steps[i] = '0;
      cache_limit = CFG_RESET;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) cache_limit = cfg_data_i;
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: step_count %0d overflow %0b",
                   $time, res_count_i, res_overflow_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (res_count_i !== want.steps) begin
            $display("%0t: step_count expected %0d got %0d",
                     $time, want.steps, res_count_i);
            fail_count_o++;
          end
          if (res_overflow_i !== want.overflow) begin
            $display("%0t: overflow expected %0b got %0b",
                     $time, want.overflow, res_overflow_i);
            fail_count_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        if (req_kind_i == KIND_PRELOAD) begin
          if (req_data_i[VAL_W-1:0] < CACHE_DEPTH)
            memo_steps[req_data_i[ADDR_W-1:0]] = req_data_i[VAL_W +: CNT_W];
        end else begin
          count_collatz_steps(req_data_i[VAL_W-1:0], want);
          expected_results.push_back(want);
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== sim/tb_collatz_step_counter_memo.sv =====
`timescale 1ns / 100ps

module tb_collatz_step_counter_memo import csm_pkg::*; ();

  localparam int unsigned MAX_GAP          = 10;
  localparam int unsigned LONG_HOLD        = 400;
  localparam int unsigned WATCHDOG_LIMIT   = 300000;
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam int unsigned RANDOM_PER_PHASE = 100;
  localparam int unsigned NUM_PHASES       = 7;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = KIND_COMPUTE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [CNT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  int   fail_count;
  int   pending;
  int   idle_cycles   = 0;
  logic idle_on       = 1'b1;
  logic long_hold_req = 1'b0;

  logic [CFG_W-1:0] phase_limits [NUM_PHASES] = '{
    CFG_W'(65536), CFG_W'(0), CFG_W'(131071), CFG_W'(2),
    CFG_W'(1000), CFG_W'(65537), CFG_W'(1)
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  collatz_step_counter_memo dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  collatz_steps_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_i    (s_axis_tready),
    .req_data_i     (s_axis_tdata),
    .req_kind_i     (s_axis_tuser),
    .res_valid_i    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_count_i    (m_axis_tdata),
    .res_overflow_i (m_axis_tuser),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_request(input logic kind, input logic [VAL_W-1:0] value,
                              input logic [CNT_W-1:0] steps);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {steps, value};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    int unsigned      pick;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] steps;
    pick  = $urandom_range(0, 99);
    steps = CNT_W'($urandom);
    if (pick < 15) begin
      case ($urandom_range(0, 9))
        0:       value = {$urandom, $urandom};
        1, 2:    value = VAL_W'($urandom_range(0, CACHE_DEPTH - 1));
        default: value = VAL_W'($urandom_range(2, 512));
      endcase
      case ($urandom_range(0, 7))
        0:       steps = '0;
        1:       steps = '1;
        2:       steps = CNT_W'($urandom);
        default: steps = CNT_W'($urandom_range(1, 300));
      endcase
      push_request(KIND_PRELOAD, value, steps);
    end else begin
      if (pick < 50)      value = VAL_W'($urandom_range(0, CACHE_DEPTH - 1));
      else if (pick < 70) value = {32'h0, $urandom};
      else if (pick < 92) value = {$urandom, $urandom};
      else                value = TRIPLE_LIMIT - 8 + VAL_W'($urandom_range(0, 16));
      push_request(KIND_COMPUTE, value, steps);
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    phase_limits[NUM_PHASES-1] = CFG_W'($urandom_range(3, CACHE_DEPTH - 1));
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_on = (p % 3 != 2);
      write_limit(phase_limits[p]);
      if (p == 1) long_hold_req = 1'b1;
      if (p == 0) begin
        push_request(KIND_COMPUTE, 64'd0, CNT_W'($urandom));
        push_request(KIND_COMPUTE, 64'd1, CNT_W'($urandom));
        push_request(KIND_COMPUTE, 64'd2, CNT_W'($urandom));
        push_request(KIND_COMPUTE, 64'd27, CNT_W'($urandom));
        push_request(KIND_COMPUTE, 64'd27, CNT_W'($urandom));
        push_request(KIND_PRELOAD, 64'd9, 16'd19);
        push_request(KIND_COMPUTE, 64'd18, CNT_W'($urandom));
        push_request(KIND_COMPUTE, 64'd36, CNT_W'($urandom));
        push_request(KIND_PRELOAD, 64'd5, '1);
        push_request(KIND_COMPUTE, 64'd10, CNT_W'($urandom));
        push_request(KIND_COMPUTE, '1, CNT_W'($urandom));
        push_request(KIND_COMPUTE, 64'h5555_5555_5555_5555, CNT_W'($urandom));
        push_request(KIND_COMPUTE, TRIPLE_LIMIT, CNT_W'($urandom));
        push_request(KIND_COMPUTE, 64'h5555_5555_5555_5553, CNT_W'($urandom));
        push_request(KIND_COMPUTE, 64'h8000_0000_0000_0000, CNT_W'($urandom));
        push_request(KIND_PRELOAD, 64'd65536, 16'd7);
        push_request(KIND_PRELOAD, '1, '1);
        push_request(KIND_PRELOAD, 64'd65535, '1);
        push_request(KIND_COMPUTE, 64'd131070, CNT_W'($urandom));
        push_request(KIND_PRELOAD, 64'd9, '0);
        push_request(KIND_COMPUTE, 64'd9, CNT_W'($urandom));
        push_request(KIND_COMPUTE, 64'd65535, CNT_W'($urandom));
      end
      repeat (RANDOM_PER_PHASE) send_random_request();
      drain_results();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
